// ----- rtl/indexed_list_append_get_remove_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the indexed list
// Concurrent checks on clk, disabled while rst is high; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_APPEND_GET_REMOVE_ASSERT_SVH
`define INDEXED_LIST_APPEND_GET_REMOVE_ASSERT_SVH

`ifndef SYNTHESIS
// Check that a property holds at every clock edge outside reset.
`define ILA_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("indexed list: property failed");
// Check that a condition never holds outside reset.
`define ILA_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("indexed list: forbidden condition seen");
`else
`define ILA_ASSERT(label, prop)
`define ILA_NEVER(label, cond)
`endif

`endif

// ----- rtl/ila_pkg.sv -----
// ----------------------------------------------------------------------------
// Indexed list package
// Sizes, operation and status codes, sequencer states and the cell control.
// ----------------------------------------------------------------------------
package ila_pkg;

  localparam int CAPACITY    = 128;
  localparam int VALUE_WIDTH = 16;

  // Request and response field widths.
  localparam int OP_W     = 2;
  localparam int VIN_W    = 16;
  localparam int POS_W    = 7;
  localparam int VOUT_W   = 16;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 8;

  // Cell index and entry count widths.
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Read-out reduction: cells per group, groups registered as a request is taken.
  localparam int GROUP      = 16;
  localparam int NUM_GROUPS = (CAPACITY + GROUP - 1) / GROUP;
  localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_GET    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic {
    FSM_IDLE   = 1'b0,
    FSM_REDUCE = 1'b1
  } fsm_t;

  typedef struct packed {
    logic                   wr_en;
    logic                   shift_en;
    logic [IDX_W-1:0]       wr_idx;
    logic [IDX_W-1:0]       pos;
    logic [VALUE_WIDTH-1:0] value;
  } cell_ctl_t;

endpackage

// ----- rtl/ila_if.sv -----
// ----------------------------------------------------------------------------
// Indexed list channels
// Valid/ready request and response channels with their payload.
// ----------------------------------------------------------------------------
interface ila_req_if;
  logic                       valid;
  logic                       ready;
  logic [ila_pkg::OP_W-1:0]   operation;
  logic [ila_pkg::VIN_W-1:0]  value_in;
  logic [ila_pkg::POS_W-1:0]  position;

  modport source (output valid, operation, value_in, position, input ready);
  modport sink   (input valid, operation, value_in, position, output ready);
endinterface

interface ila_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ila_pkg::VOUT_W-1:0]   value_out;
  logic [ila_pkg::STATUS_W-1:0] status;
  logic [ila_pkg::LEN_W-1:0]    length;

  modport source (output valid, value_out, status, length, input ready);
  modport sink   (input valid, value_out, status, length, output ready);
endinterface

// ----- rtl/ila_cell.sv -----
// ----------------------------------------------------------------------------
// Indexed list cell
// One entry: write on append, take the upper neighbor on remove, gated read.
// ----------------------------------------------------------------------------
module ila_cell (
  input  logic                            clk,
  input  logic [ila_pkg::IDX_W-1:0]       my_idx,
  input  ila_pkg::cell_ctl_t              ctl,
  input  logic [ila_pkg::VALUE_WIDTH-1:0] upper,
  output logic [ila_pkg::VALUE_WIDTH-1:0] value,
  output logic [ila_pkg::VALUE_WIDTH-1:0] masked
);

  always_ff @(posedge clk) begin
    if (ctl.wr_en && (my_idx == ctl.wr_idx)) begin
      value <= ctl.value;
    end else if (ctl.shift_en && (my_idx >= ctl.pos)) begin
      value <= upper;
    end
  end

  assign masked = (my_idx == ctl.pos) ? value : '0;

endmodule

// ----- rtl/ila_array.sv -----
// ----------------------------------------------------------------------------
// Indexed list cell row
// Chain of cells with a two-level OR reduction of the selected entry.
// ----------------------------------------------------------------------------
module ila_array (
  input  logic                            clk,
  input  ila_pkg::cell_ctl_t              ctl,
  input  logic                            sample,
  output logic [ila_pkg::VALUE_WIDTH-1:0] read_value
);

  logic [ila_pkg::VALUE_WIDTH-1:0] vals   [ila_pkg::CAPACITY];
  logic [ila_pkg::VALUE_WIDTH-1:0] masked [ila_pkg::CAPACITY];
  logic [ila_pkg::VALUE_WIDTH-1:0] grp_or [ila_pkg::NUM_GROUPS];
  logic [ila_pkg::VALUE_WIDTH-1:0] grp_q  [ila_pkg::NUM_GROUPS];

  for (genvar i = 0; i < ila_pkg::CAPACITY; i++) begin : g_cell
    logic [ila_pkg::VALUE_WIDTH-1:0] upper;
    if (i == ila_pkg::CAPACITY - 1) begin : g_top
      assign upper = vals[i];
    end else begin : g_mid
      assign upper = vals[i+1];
    end
    ila_cell u_cell (
      .clk    (clk),
      .my_idx (ila_pkg::IDX_W'(i)),
      .ctl    (ctl),
      .upper  (upper),
      .value  (vals[i]),
      .masked (masked[i])
    );
  end

  // First level: OR each group of cells; only the addressed cell is non-zero.
  always_comb begin
    for (int g = 0; g < ila_pkg::NUM_GROUPS; g++) begin
      grp_or[ila_pkg::GRP_W'(g)] = '0;
      for (int k = 0; k < ila_pkg::GROUP; k++) begin
        if (g * ila_pkg::GROUP + k < ila_pkg::CAPACITY) begin
          grp_or[ila_pkg::GRP_W'(g)] = grp_or[ila_pkg::GRP_W'(g)]
                                     | masked[ila_pkg::IDX_W'(g * ila_pkg::GROUP + k)];
        end
      end
    end
  end

  // Hold the group results until the next request is taken.
  always_ff @(posedge clk) begin
    if (sample) begin
      grp_q <= grp_or;
    end
  end

  always_comb begin
    read_value = '0;
    for (int g = 0; g < ila_pkg::NUM_GROUPS; g++) begin
      read_value = read_value | grp_q[ila_pkg::GRP_W'(g)];
    end
  end

endmodule

// ----- rtl/indexed_list_append_get_remove.sv -----
// ----------------------------------------------------------------------------
// Indexed list: append, get, remove at position, clear
// Bounded ordered list held in a row of cells, one request in flight at a time.
// ----------------------------------------------------------------------------
// Usage:
//   request  (sink): operation, value_in, position; taken on valid && ready.
//   response (source): value_out, status, length; one response per request.
//   A request is taken in the idle state: the cells update (append
//   writes the cell at the current length, remove makes every cell at or
//   above the position take its upper neighbor) and each group of sixteen
//   cells ORs its addressed entry into a group register. In the reduce
//   state the group registers are ORed and the response register loads;
//   only then does the block return to idle and take the next request.
//   The response register lets a new request in while the last response
//   waits; if the receiver still stalls when the next result is ready, the
//   block holds in its reduce state with ready low until the slot frees.
//   Reset empties the list (length zero) and drops any pending response;
//   entry contents are not cleared, as no entry at or above the length is
//   ever read.
// ----------------------------------------------------------------------------
`include "indexed_list_append_get_remove_assert.svh"

module indexed_list_append_get_remove (
  input  logic       clk,
  input  logic       rst,
  ila_req_if.sink    request,
  ila_rsp_if.source  response
);

  ila_pkg::fsm_t      state;
  ila_pkg::fsm_t      state_next;
  ila_pkg::op_t       op;
  ila_pkg::status_t   status_now;
  ila_pkg::status_t   status_q;
  ila_pkg::cell_ctl_t ctl;

  logic [ila_pkg::CNT_W-1:0]       count;
  logic [ila_pkg::CNT_W-1:0]       count_next;
  logic [ila_pkg::VALUE_WIDTH-1:0] read_value;
  logic                            accept;
  logic                            hit;
  logic                            full;
  logic                            found_now;
  logic                            found_q;
  logic                            load_out;

  assign accept = request.valid && request.ready;
  assign op     = ila_pkg::op_t'(request.operation);
  assign hit    = ila_pkg::CMP_W'(request.position) < ila_pkg::CMP_W'(count);
  assign full   = (count == ila_pkg::CNT_W'(ila_pkg::CAPACITY));

  // Decide status, new length and cell commands for the incoming request.
  always_comb begin
    status_now   = ila_pkg::ST_OK;
    found_now    = 1'b0;
    count_next   = count;
    ctl.wr_en    = 1'b0;
    ctl.shift_en = 1'b0;
    ctl.wr_idx   = ila_pkg::IDX_W'(count);
    ctl.pos      = ila_pkg::IDX_W'(request.position);
    ctl.value    = ila_pkg::VALUE_WIDTH'(request.value_in);
    case (op)
      ila_pkg::OP_APPEND: begin
        if (full) begin
          status_now = ila_pkg::ST_FULL;
        end else begin
          ctl.wr_en  = accept;
          count_next = count + ila_pkg::CNT_W'(1);
        end
      end
      ila_pkg::OP_GET: begin
        if (hit) begin
          found_now = 1'b1;
        end else begin
          status_now = ila_pkg::ST_NOT_FOUND;
        end
      end
      ila_pkg::OP_REMOVE: begin
        if (hit) begin
          found_now    = 1'b1;
          ctl.shift_en = accept;
          count_next   = count - ila_pkg::CNT_W'(1);
        end else begin
          status_now = ila_pkg::ST_NOT_FOUND;
        end
      end
      ila_pkg::OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
        status_now = ila_pkg::ST_OK;
      end
    endcase
  end

  ila_array u_array (
    .clk        (clk),
    .ctl        (ctl),
    .sample     (accept),
    .read_value (read_value)
  );

  // Sequencer: take a request, then finish the read-out.
  always_comb begin
    state_next = state;
    case (state)
      ila_pkg::FSM_IDLE: begin
        if (accept) begin
          state_next = ila_pkg::FSM_REDUCE;
        end
      end
      ila_pkg::FSM_REDUCE: begin
        if (load_out) begin
          state_next = ila_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_next = ila_pkg::FSM_IDLE;
      end
    endcase
  end

  always_comb begin
    request.ready = 1'b0;
    load_out      = 1'b0;
    case (state)
      ila_pkg::FSM_IDLE: begin
        request.ready = 1'b1;
      end
      ila_pkg::FSM_REDUCE: begin
        load_out = !response.valid || response.ready;
      end
      default: begin
        request.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ila_pkg::FSM_IDLE;
      count          <= '0;
      response.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        count <= count_next;
      end
      // Load the response slot, or drop it once taken.
      if (load_out) begin
        response.valid <= 1'b1;
      end else if (response.ready) begin
        response.valid <= 1'b0;
      end
    end
  end

  // Hold request results across the reduce state; load the response.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_q <= status_now;
      found_q  <= found_now;
    end
    if (load_out) begin
      response.value_out <= found_q ? ila_pkg::VOUT_W'(read_value) : '0;
      response.status    <= status_q;
      response.length    <= ila_pkg::LEN_W'(count);
    end
  end

  `ILA_NEVER(a_count_bound, count > ila_pkg::CNT_W'(ila_pkg::CAPACITY))
  `ILA_ASSERT(a_accept_reduce, accept |=> (state == ila_pkg::FSM_REDUCE))
  `ILA_ASSERT(a_remove_shrinks, (accept && ctl.shift_en) |=> (count == $past(count_next)))
  `ILA_ASSERT(a_full_status, ((state == ila_pkg::FSM_REDUCE) && (status_q == ila_pkg::ST_FULL)) |-> full)

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list testbench
// Drives append, get, remove and clear requests, with directed corner cases,
// a full-list pass, and random traffic under several idle and stall mixes.
// A shadow copy of the list predicts each response. A checker compares every
// response field by field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tb;

  localparam time CLK_PERIOD   = 12ns;
  localparam int  RESET_CYCLES = 7;
  localparam int  QUIET_LIMIT  = 2000;  // cycles with no handshake on either side
  localparam int  HOLD_OFF     = 80;    // long receiver hold-off, in cycles
  localparam int  SETTLE       = 8;     // cycles after the last response

  // One predicted response.
  typedef struct {
    logic [ila_pkg::VOUT_W-1:0] value;
    ila_pkg::status_t           status;
    logic [ila_pkg::LEN_W-1:0]  length;
  } list_reply_t;

  logic clk;
  logic rst;

  ila_req_if req_ch ();
  ila_rsp_if rsp_ch ();

  indexed_list_append_get_remove DUT (
    .clk      (clk),
    .rst      (rst),
    .request  (req_ch),
    .response (rsp_ch)
  );

  // Shadow of the list contents and length.
  logic [ila_pkg::VALUE_WIDTH-1:0] shadow_cells [ila_pkg::CAPACITY];
  int                              shadow_len;

  // Predicted responses, oldest first.
  list_reply_t pending_replies [$];

  // Traffic shaping, in percent of cycles.
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_left;

  int errors;
  int quiet_cycles;

  // Coverage tallies for the summary.
  int op_tally     [4];
  int status_tally [3];
  int peak_len;

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction: apply one request to the shadow list and return the response.
  // Only cells below the shadow length are ever read.
  // --------------------------------------------------------------------------
  function automatic list_reply_t apply_list_op(ila_pkg::op_t op,
                                                logic [ila_pkg::VIN_W-1:0] val,
                                                logic [ila_pkg::POS_W-1:0] pos);
    list_reply_t r;
    r.value  = '0;
    r.status = ila_pkg::ST_OK;
    case (op)
      ila_pkg::OP_APPEND: begin
        // A full list drops the value.
        if (shadow_len >= ila_pkg::CAPACITY) begin
          r.status = ila_pkg::ST_FULL;
        end else begin
          shadow_cells[ila_pkg::IDX_W'(shadow_len)] = val[ila_pkg::VALUE_WIDTH-1:0];
          shadow_len++;
        end
      end
      ila_pkg::OP_GET, ila_pkg::OP_REMOVE: begin
        // A position at or past the end leaves the list untouched.
        if (int'(pos) >= shadow_len) begin
          r.status = ila_pkg::ST_NOT_FOUND;
        end else begin
          r.value = shadow_cells[pos];
          if (op == ila_pkg::OP_REMOVE) begin
            // Close the gap: every later entry moves down one place.
            for (int i = int'(pos); i < shadow_len - 1; i++)
              shadow_cells[ila_pkg::IDX_W'(i)] = shadow_cells[ila_pkg::IDX_W'(i + 1)];
            shadow_len--;
          end
        end
      end
      default: begin
        shadow_len = 0;
      end
    endcase
    r.length = shadow_len[ila_pkg::LEN_W-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: called at a falling edge, returns at a falling edge. Valid stays
  // high after an accepted request, so the next call either keeps it high or
  // drops it for an idle cycle; it never gets two assignments in one step.
  // --------------------------------------------------------------------------
  task automatic send_request(ila_pkg::op_t op, logic [ila_pkg::VIN_W-1:0] val,
                              logic [ila_pkg::POS_W-1:0] pos);
    // Insert random idle cycles ahead of the request.
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.value_in  <= val;
    req_ch.position  <= pos;
    // Hold the request until the block takes it.
    do @(posedge clk); while (!req_ch.ready);
    pending_replies.push_back(apply_list_op(op, val, pos));
    op_tally[op]++;
    if (shadow_len > peak_len) peak_len = shadow_len;
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted response has come back.
  task automatic wait_all_replies();
    req_ch.valid <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: ready changes at the falling edge. A pending hold-off keeps
  // ready low for its full count, otherwise stall at the current rate.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_off_left--;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Response checker: compare each accepted response with the oldest
  // prediction; keep going after a mismatch.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_reply
    list_reply_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (rsp_ch.status < 3) status_tally[rsp_ch.status]++;
      if (pending_replies.size() == 0) begin
        errors++;
        $display("%0t: response with none expected: value_out=%h status=%0d length=%0d",
                 $time, rsp_ch.value_out, rsp_ch.status, rsp_ch.length);
      end else begin
        want = pending_replies.pop_front();
        if (rsp_ch.value_out !== want.value) begin
          errors++;
          $display("%0t: value_out mismatch: expected %h, got %h",
                   $time, want.value, rsp_ch.value_out);
        end
        if (rsp_ch.status !== want.status) begin
          errors++;
          $display("%0t: status mismatch: expected %0d, got %0d",
                   $time, want.status, rsp_ch.status);
        end
        if (rsp_ch.length !== want.length) begin
          errors++;
          $display("%0t: length mismatch: expected %0d, got %0d",
                   $time, want.length, rsp_ch.length);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when neither channel moves for too long.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d responses outstanding",
               $time, QUIET_LIMIT, pending_replies.size());
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Corner cases on a short list: empty-list reads, field extremes, remove
  // at the front, in the middle and at the end, past-the-end positions, and
  // clear on a filled and on an empty list.
  task automatic test_directed();
    send_request(ila_pkg::OP_GET,    16'h0000, 7'd0);    // empty list
    send_request(ila_pkg::OP_REMOVE, 16'hFFFF, 7'd127);  // empty list, top position
    send_request(ila_pkg::OP_APPEND, 16'h0000, 7'd0);
    send_request(ila_pkg::OP_APPEND, 16'hFFFF, 7'd127);
    send_request(ila_pkg::OP_APPEND, 16'hA5A5, 7'h55);
    send_request(ila_pkg::OP_APPEND, 16'h5A5A, 7'h2A);
    send_request(ila_pkg::OP_GET,    16'hFFFF, 7'd0);
    send_request(ila_pkg::OP_GET,    16'h0000, 7'd3);    // last entry
    send_request(ila_pkg::OP_GET,    16'h0000, 7'd4);    // exactly at the length
    send_request(ila_pkg::OP_GET,    16'h0000, 7'd127);
    send_request(ila_pkg::OP_REMOVE, 16'h0000, 7'd1);    // middle: later entries move down
    send_request(ila_pkg::OP_GET,    16'h0000, 7'd1);
    send_request(ila_pkg::OP_REMOVE, 16'h0000, 7'd2);    // last entry
    send_request(ila_pkg::OP_REMOVE, 16'h0000, 7'd2);    // now past the end
    send_request(ila_pkg::OP_REMOVE, 16'h0000, 7'd0);    // first entry
    send_request(ila_pkg::OP_GET,    16'h0000, 7'd0);
    send_request(ila_pkg::OP_CLEAR,  16'hFFFF, 7'd127);
    send_request(ila_pkg::OP_GET,    16'h0000, 7'd0);
    send_request(ila_pkg::OP_REMOVE, 16'h0000, 7'd0);
    send_request(ila_pkg::OP_CLEAR,  16'h0000, 7'd0);    // clear an empty list
    send_request(ila_pkg::OP_APPEND, 16'h8001, 7'd0);
  endtask

  // Fill the list, push appends against the full list, and work the ends.
  task automatic test_full_list();
    send_request(ila_pkg::OP_CLEAR, 16'h0000, 7'd0);
    repeat (ila_pkg::CAPACITY)
      send_request(ila_pkg::OP_APPEND, ila_pkg::VIN_W'($urandom),
                   ila_pkg::POS_W'($urandom));
    send_request(ila_pkg::OP_APPEND, 16'hFFFF, 7'd0);     // full: dropped
    send_request(ila_pkg::OP_APPEND, 16'h1234, 7'd127);   // full: dropped
    send_request(ila_pkg::OP_GET,    16'h0000, 7'd127);   // top cell
    send_request(ila_pkg::OP_REMOVE, 16'h0000, 7'd127);   // top cell
    send_request(ila_pkg::OP_GET,    16'h0000, 7'd127);   // now past the end
    send_request(ila_pkg::OP_APPEND, 16'hBEEF, 7'd0);     // refill
    send_request(ila_pkg::OP_REMOVE, 16'h0000, 7'd0);     // shift the whole list
    send_request(ila_pkg::OP_GET,    16'h0000, 7'd126);
    send_request(ila_pkg::OP_CLEAR,  16'h0000, 7'd0);
  endtask

  // Random traffic: mostly positions inside the list, some past the end,
  // rare clears. The append share decides how deep the list grows.
  task automatic test_random(int items, int idle_pct, int stall_pct, int append_pct);
    int                        pick;
    ila_pkg::op_t              op;
    logic [ila_pkg::POS_W-1:0] pos;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (items) begin
      pick = $urandom_range(99);
      if (pick < 1)                                        op = ila_pkg::OP_CLEAR;
      else if (pick < append_pct)                          op = ila_pkg::OP_APPEND;
      else if (pick < append_pct + (100 - append_pct) / 2) op = ila_pkg::OP_GET;
      else                                                 op = ila_pkg::OP_REMOVE;
      if (shadow_len > 0 && $urandom_range(9) < 8)
        pos = ila_pkg::POS_W'($urandom_range(shadow_len - 1));
      else
        pos = ila_pkg::POS_W'($urandom);
      send_request(op, ila_pkg::VIN_W'($urandom), pos);
    end
  endtask

  // Hold the receiver off while requests keep coming, so the block backs up and
  // drops request ready; then pause the sender until all is back, and send more.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_off_left = HOLD_OFF;
    @(negedge clk);
    repeat (24) send_request(ila_pkg::op_t'($urandom_range(2)), ila_pkg::VIN_W'($urandom),
                             ila_pkg::POS_W'($urandom_range(shadow_len)));
    wait_all_replies();
    repeat (16) send_request(ila_pkg::op_t'($urandom_range(2)), ila_pkg::VIN_W'($urandom),
                             ila_pkg::POS_W'($urandom_range(shadow_len)));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.operation = ila_pkg::OP_APPEND;
    req_ch.value_in  = '0;
    req_ch.position  = '0;
    rsp_ch.ready     = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_off_left    = 0;
    shadow_len       = 0;
    errors           = 0;
    quiet_cycles     = 0;
    peak_len         = 0;
    foreach (op_tally[i]) op_tally[i] = 0;
    foreach (status_tally[i]) status_tally[i] = 0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_full_list();
    // Grow deep with no idling, then shrink and regrow under each mix.
    test_random(330, 0,  0,  75);
    test_random(330, 63, 0,  40);
    test_backpressure();
    test_random(330, 0,  63, 70);
    test_random(330, 29, 29, 50);

    wait_all_replies();
    repeat (SETTLE) @(negedge clk);

    $display("Covered %0d appends, %0d gets, %0d removes, %0d clears; list peaked at %0d.",
             op_tally[ila_pkg::OP_APPEND], op_tally[ila_pkg::OP_GET],
             op_tally[ila_pkg::OP_REMOVE], op_tally[ila_pkg::OP_CLEAR], peak_len);
    $display("Responses: %0d ok, %0d past the end, %0d full; %0d mismatches.",
             status_tally[ila_pkg::ST_OK], status_tally[ila_pkg::ST_NOT_FOUND],
             status_tally[ila_pkg::ST_FULL], errors);
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/ila_pkg.sv
rtl/ila_if.sv
rtl/ila_cell.sv
rtl/ila_array.sv
rtl/indexed_list_append_get_remove.sv
bench/tb.sv
